// ===== sv/mtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbl_pkg: shared types and constants of the move-to-back list cipher
// Holds the list geometry, the cell command set and the controller states.
// ----------------------------------------------------------------------------
package mtbl_pkg;

   localparam int LIST_DEPTH = 256;
   localparam int SYM_W      = 8;
   localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address of the configuration port.
   localparam logic REG_DECRYPT_MODE = 1'b0;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_ROTATE,
      CELL_POP,
      CELL_APPEND
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [SYM_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== sv/mtbl_cell.sv =====
// ----------------------------------------------------------------------------
// mtbl_cell: one position of the symbol list
// Holds one symbol and an occupied bit, and shifts toward the head on command.
// ----------------------------------------------------------------------------
module mtbl_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  mtbl_pkg::cell_cmd_type     cmd,
   input  logic [mtbl_pkg::SYM_W-1:0] fb_data,
   input  logic                       next_occ,
   input  logic [mtbl_pkg::SYM_W-1:0] next_data,
   input  logic                       prev_occ,
   output logic                       occ,
   output logic [mtbl_pkg::SYM_W-1:0] data
);

   logic                       occ_ff;
   logic                       occ_in;
   logic [mtbl_pkg::SYM_W-1:0] data_ff;
   logic [mtbl_pkg::SYM_W-1:0] data_in;

   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      unique case (cmd.op)
         mtbl_pkg::CELL_HOLD: begin
         end
         mtbl_pkg::CELL_CLEAR: begin
            occ_in = 1'b0;
         end
         mtbl_pkg::CELL_ROTATE: begin
            // The last occupied cell receives the symbol leaving the head.
            data_in = next_occ ? next_data : fb_data;
            occ_in  = next_occ | occ_ff;
         end
         mtbl_pkg::CELL_POP: begin
            data_in = next_data;
            occ_in  = next_occ;
         end
         mtbl_pkg::CELL_APPEND: begin
            if (!occ_ff && prev_occ) begin
               data_in = cmd.value;
               occ_in  = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ  = occ_ff;
   assign data = data_ff;

endmodule

// ===== sv/mtbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtbl_ctrl: sequencer of the move-to-back list cipher
// Scans the list as it recirculates through the head cell, picks the
// neighbor symbol, steers the move to the list end and holds the response.
// ----------------------------------------------------------------------------
module mtbl_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       decrypt_mode,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [mtbl_pkg::SYM_W-1:0] req_data_in,
   input  logic                       req_first_of_message,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mtbl_pkg::SYM_W-1:0] rsp_data_out,
   output logic                       rsp_list_full,
   input  logic [mtbl_pkg::SYM_W-1:0] head_data,
   output mtbl_pkg::cell_cmd_type     cmd
);

   mtbl_pkg::state_type        state_ff, state_in;
   logic [mtbl_pkg::LEN_W-1:0] length_ff, length_in;
   logic [mtbl_pkg::LEN_W-1:0] step_ff, step_in;
   logic [mtbl_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [mtbl_pkg::SYM_W-1:0] prev_ff, prev_in;
   logic [mtbl_pkg::SYM_W-1:0] first_ff, first_in;
   logic [mtbl_pkg::SYM_W-1:0] result_ff, result_in;
   logic                       hit_ff, hit_in;
   logic                       pend_ff, pend_in;
   logic                       wrap_ff, wrap_in;
   logic                       take_last_ff, take_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [mtbl_pkg::SYM_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic                       out_free;
   logic                       last_step;
   logic                       match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == length_ff - mtbl_pkg::LEN_W'(1));
   assign match     = (head_data == sym_ff);

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      step_in      = step_ff;
      sym_in       = sym_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      result_in    = result_ff;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      wrap_in      = wrap_ff;
      take_last_in = take_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_full_in  = rsp_full_ff;
      req_ready    = 1'b0;
      cmd.op       = mtbl_pkg::CELL_HOLD;
      cmd.value    = sym_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mtbl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sym_in       = req_data_in;
               step_in      = '0;
               hit_in       = 1'b0;
               pend_in      = 1'b0;
               wrap_in      = 1'b0;
               take_last_in = 1'b0;
               if (req_first_of_message) begin
                  cmd.op    = mtbl_pkg::CELL_CLEAR;
                  length_in = '0;
                  state_in  = mtbl_pkg::ST_FINISH;
               end else if (length_ff == '0) begin
                  state_in = mtbl_pkg::ST_FINISH;
               end else begin
                  state_in = mtbl_pkg::ST_SCAN;
               end
            end
         end

         mtbl_pkg::ST_SCAN: begin
            step_in = step_ff + mtbl_pkg::LEN_W'(1);
            prev_in = head_data;
            if (step_ff == '0) begin
               first_in = head_data;
            end
            if (last_step) begin
               state_in = mtbl_pkg::ST_FINISH;
            end

            if (!decrypt_mode) begin
               // Encrypt: the matching symbol leaves the ring here and its
               // predecessor is the symbol that left just before it.
               if (match) begin
                  cmd.op = mtbl_pkg::CELL_POP;
                  hit_in = 1'b1;
                  if (step_ff == '0) begin
                     take_last_in = 1'b1;
                  end else begin
                     result_in = prev_ff;
                  end
               end else begin
                  cmd.op = mtbl_pkg::CELL_ROTATE;
               end
               // A match at the head wraps to the last symbol of the list.
               if (last_step && (take_last_ff || (match && step_ff == '0))) begin
                  result_in = head_data;
               end
            end else begin
               // Decrypt: the symbol after the match is the result and the
               // one that moves to the end.
               if (pend_ff) begin
                  cmd.op    = mtbl_pkg::CELL_POP;
                  result_in = head_data;
                  pend_in   = 1'b0;
               end else begin
                  cmd.op = mtbl_pkg::CELL_ROTATE;
               end
               if (match) begin
                  hit_in = 1'b1;
                  if (last_step) begin
                     // The successor of the last symbol is the first one,
                     // which one more rotation moves to the end.
                     wrap_in   = 1'b1;
                     result_in = (step_ff == '0) ? head_data : first_ff;
                  end else begin
                     pend_in = 1'b1;
                  end
               end
            end
         end

         mtbl_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in     = mtbl_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_full_in  = 1'b0;
               rsp_data_in  = hit_ff ? result_ff : sym_ff;
               if (!hit_ff) begin
                  if (length_ff < mtbl_pkg::LEN_W'(mtbl_pkg::LIST_DEPTH)) begin
                     cmd.op    = mtbl_pkg::CELL_APPEND;
                     cmd.value = sym_ff;
                     length_in = length_ff + mtbl_pkg::LEN_W'(1);
                  end else begin
                     rsp_full_in = 1'b1;
                  end
               end else if (wrap_ff) begin
                  cmd.op = mtbl_pkg::CELL_ROTATE;
               end else begin
                  cmd.op    = mtbl_pkg::CELL_APPEND;
                  cmd.value = decrypt_mode ? result_ff : sym_ff;
               end
            end
         end

         default: begin
            state_in = mtbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtbl_pkg::ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      sym_ff       <= sym_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      result_ff    <= result_in;
      hit_ff       <= hit_in;
      pend_ff      <= pend_in;
      wrap_ff      <= wrap_in;
      take_last_ff <= take_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_list_full = rsp_full_ff;

`ifndef SYNTHESIS
   a_clear_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mtbl_pkg::CELL_CLEAR) |-> (req_valid && req_ready))
      else $error("list cleared outside of a request");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= mtbl_pkg::LEN_W'(mtbl_pkg::LIST_DEPTH))
      else $error("list length beyond depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtbl_pkg::ST_SCAN) |-> (step_ff < length_ff))
      else $error("scan step past the list end");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtbl_pkg::ST_FINISH && out_free) |=>
         (rsp_valid && state_ff == mtbl_pkg::ST_IDLE))
      else $error("finished request did not produce a response");

   a_full_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtbl_pkg::ST_FINISH && out_free && hit_ff) |=> !rsp_list_full)
      else $error("full flag raised for a known symbol");
`endif

endmodule

// ===== sv/move_to_back_list_cipher.sv =====
// ----------------------------------------------------------------------------
// move_to_back_list_cipher: byte cipher over a move-to-back symbol list
// A row of list cells recirculates through its head, where each request is
// compared, its neighbor symbol picked and the plain symbol moved to the end.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake                Content
//   req_*        in          req_valid / req_ready    data_in, first_of_message
//   rsp_*        out         rsp_valid / rsp_ready    data_out, list_full
//   csr_*        in/out      APB, pready always high  decrypt_mode at word 0
//
// A request is accepted in the idle state after an optional clear; the scan
// state then passes the whole list once through the head cell, and the
// finish state appends or moves the symbol and loads the response register.
// Reset empties the list and sets encrypt mode. A request is taken while an
// earlier response waits; a stalled response holds the sequencer in its
// finish state until the response register is free.
//
module move_to_back_list_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mtbl_pkg::SYM_W-1:0]      req_data_in,
   input  logic                            req_first_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mtbl_pkg::SYM_W-1:0]      rsp_data_out,
   output logic                            rsp_list_full,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mtbl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mtbl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mtbl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic                       decrypt_mode_ff;
   logic                       decrypt_mode_in;
   mtbl_pkg::cell_cmd_type     cmd;
   logic [mtbl_pkg::LIST_DEPTH-1:0] cell_occ;
   logic [mtbl_pkg::SYM_W-1:0] cell_data [mtbl_pkg::LIST_DEPTH];

   // Configuration register.
   assign csr_pready = 1'b1;

   always_comb begin
      decrypt_mode_in = decrypt_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[mtbl_pkg::CSR_ADDR_W-1] == mtbl_pkg::REG_DECRYPT_MODE) begin
         decrypt_mode_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[mtbl_pkg::CSR_ADDR_W-1] == mtbl_pkg::REG_DECRYPT_MODE) begin
         csr_prdata[0] = decrypt_mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
      end else begin
         decrypt_mode_ff <= decrypt_mode_in;
      end
   end

   mtbl_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .decrypt_mode         (decrypt_mode_ff),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_in          (req_data_in),
      .req_first_of_message (req_first_of_message),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_data_out         (rsp_data_out),
      .rsp_list_full        (rsp_list_full),
      .head_data            (cell_data[0]),
      .cmd                  (cmd)
   );

   // The list runs from cell 0 (head) toward the last cell; the head symbol
   // feeds back to whichever cell is the current tail.
   for (genvar i = 0; i < mtbl_pkg::LIST_DEPTH; i++) begin : g_cell
      logic                       next_occ;
      logic [mtbl_pkg::SYM_W-1:0] next_data;
      logic                       prev_occ;

      if (i == mtbl_pkg::LIST_DEPTH - 1) begin : g_tail
         assign next_occ  = 1'b0;
         assign next_data = '0;
      end else begin : g_inner
         assign next_occ  = cell_occ[i+1];
         assign next_data = cell_data[i+1];
      end

      if (i == 0) begin : g_head
         assign prev_occ = 1'b1;
      end else begin : g_body
         assign prev_occ = cell_occ[i-1];
      end

      mtbl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .fb_data   (cell_data[0]),
         .next_occ  (next_occ),
         .next_data (next_data),
         .prev_occ  (prev_occ),
         .occ       (cell_occ[i]),
         .data      (cell_data[i])
      );
   end

endmodule
